// ===== src/vccd_pkg.sv =====
// ----------------------------------------------------------------------------
// vccd_pkg
// Shared types and constants for the video clip dropout detector.
// ----------------------------------------------------------------------------
package vccd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ASTART_W = 12;

  // Margin = floor(2*(white-black)/25) for a 17-bit doubled difference.
  // Reciprocal of 25 scaled by 2^24, rounded up; exact over the full range.
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 24;
  localparam int PROD_W      = DIFF_W + RECIP_W;
  localparam int MARGIN_W    = 13;
  localparam logic [RECIP_W-1:0] RECIP_25 = 20'd671089;

  typedef enum logic [1:0] {
    REG_WHITE  = 2'd0,
    REG_BLACK  = 2'd1,
    REG_ASTART = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
  } thr_t;

endpackage

// ===== src/video_clip_dropout_detector.sv =====
// ----------------------------------------------------------------------------
// video_clip_dropout_detector
// Finds clip (over/undershoot) events in active-area video samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one sample per item in raster
//   order, with its line number and a flag on the last active sample.
//   Output channel (out_valid/out_ready) gives at most one event per input
//   item: start x, end x and line number plus one.
//   Configuration channel (cfg_valid/cfg_ready) writes white level, black
//   level and active start by index; it is always ready.
// Throughput: one item per clock unless the input is held off. The history of
//   out-of-range flags is a row of WINDOW-1 cells shifting once per item;
//   the search for the farthest flagged sample is registered with the shift.
// Latency: an event is registered and shown the cycle after the item that
//   completes it is accepted.
// After reset, and after any white or black write, the input is held off
//   while the two-stage threshold unit settles.
// A stalled output register holds the input off until the event is taken.
// ----------------------------------------------------------------------------
module video_clip_dropout_detector #(
  parameter int WINDOW    = 20,
  parameter int LINE_BITS = 10,
  parameter int X_BITS    = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vccd_pkg::SAMPLE_W-1:0] sample,
  input  logic [LINE_BITS-1:0]          line_number,
  input  logic                          last_in_line,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [X_BITS-1:0]             start_x,
  output logic [X_BITS-1:0]             end_x,
  output logic [LINE_BITS:0]            event_line,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [vccd_pkg::SAMPLE_W-1:0] cfg_data
);

  localparam int HW = WINDOW - 1;
  localparam int BW = $clog2(WINDOW);
  localparam int SW = $clog2(WINDOW + 1);
  localparam int EW = LINE_BITS + 1;

  // configuration
  logic [vccd_pkg::SAMPLE_W-1:0] white_level;
  logic [vccd_pkg::SAMPLE_W-1:0] black_level;
  logic [vccd_pkg::ASTART_W-1:0] active_start;
  logic [1:0]                    settle;
  vccd_pkg::thr_t                thr;

  // line state
  logic [HW-1:0]        hist;
  logic [HW-1:0]        hist_next;
  logic [BW-1:0]        back, back_next;
  logic [X_BITS-1:0]    x_pos, x_pos_next;
  logic [SW-1:0]        skip, skip_next;
  logic [BW-1:0]        fwd, fwd_next;
  logic                 pend_valid, pend_valid_next;
  logic                 pend_wide, pend_wide_next;
  logic                 first_of_line, first_of_line_next;
  logic [X_BITS-1:0]    pend_start, pend_start_next;
  logic [X_BITS-1:0]    pend_end, pend_end_next;
  logic [LINE_BITS-1:0] pend_line, pend_line_next;

  logic accept, nom, trig, new_bit, emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (settle == 2'd0) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_level  <= '1;
      black_level  <= '0;
      active_start <= '0;
      settle       <= 2'd2;
    end else begin
      if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          vccd_pkg::REG_WHITE: begin
            white_level <= cfg_data;
            settle      <= 2'd2;
          end
          vccd_pkg::REG_BLACK: begin
            black_level <= cfg_data;
            settle      <= 2'd2;
          end
          vccd_pkg::REG_ASTART: begin
            active_start <= cfg_data[vccd_pkg::ASTART_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  vccd_thresh u_thresh (
    .clk         (clk),
    .white_level (white_level),
    .black_level (black_level),
    .thr         (thr)
  );

  // history line: cell 0 takes the newest flag
  genvar gi;
  generate
    for (gi = 0; gi < HW; gi++) begin : g_cell
      logic din;
      if (gi == 0) begin : g_head
        assign din = new_bit;
      end else begin : g_body
        assign din = hist[gi-1];
      end
      vccd_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (accept),
        .clear (last_in_line),
        .din   (din),
        .q     (hist[gi])
      );
    end
  endgenerate

  always_comb begin
    nom  = (sample < black_level) || (sample > white_level);
    trig = (sample < thr.lo) || (sample > thr.hi);
    new_bit = nom && !first_of_line;

    emit               = 1'b0;
    pend_valid_next    = pend_valid;
    pend_wide_next     = pend_wide;
    pend_start_next    = pend_start;
    pend_end_next      = pend_end;
    pend_line_next     = pend_line;
    fwd_next           = fwd;
    skip_next          = skip;

    // forward window of an open event
    if (pend_valid) begin
      if (nom) begin
        pend_end_next  = x_pos;
        pend_wide_next = 1'b1;
      end
      if (fwd != '0) begin
        fwd_next = fwd - BW'(1);
      end
      if (fwd_next == '0 || last_in_line) begin
        emit            = pend_wide_next;
        pend_valid_next = 1'b0;
      end
    end

    if (skip != '0) begin
      skip_next = skip - SW'(1);
    end else if (trig && !emit) begin
      pend_start_next = x_pos - X_BITS'(back);
      pend_end_next   = x_pos;
      pend_line_next  = line_number;
      pend_wide_next  = (back != '0);
      skip_next       = SW'(WINDOW);
      if (last_in_line) begin
        emit            = pend_wide_next;
        pend_valid_next = 1'b0;
        fwd_next        = '0;
      end else begin
        pend_valid_next = 1'b1;
        fwd_next        = BW'(WINDOW - 1);
      end
    end

    if (last_in_line) begin
      skip_next          = '0;
      pend_valid_next    = 1'b0;
      fwd_next           = '0;
      x_pos_next         = X_BITS'(active_start);
      first_of_line_next = 1'b1;
      hist_next          = '0;
    end else begin
      x_pos_next         = x_pos + X_BITS'(1);
      first_of_line_next = 1'b0;
      hist_next          = (hist << 1) | HW'(new_bit);
    end

    // distance back to the farthest flagged sample after this shift
    back_next = '0;
    for (int k = 1; k <= HW; k++) begin
      if (hist_next[k-1]) begin
        back_next = BW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos         <= '0;
      skip          <= '0;
      fwd           <= '0;
      back          <= '0;
      pend_valid    <= 1'b0;
      pend_wide     <= 1'b0;
      first_of_line <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        x_pos         <= x_pos_next;
        skip          <= skip_next;
        fwd           <= fwd_next;
        back          <= back_next;
        pend_valid    <= pend_valid_next;
        pend_wide     <= pend_wide_next;
        first_of_line <= first_of_line_next;
        pend_start    <= pend_start_next;
        pend_end      <= pend_end_next;
        pend_line     <= pend_line_next;
      end
      if (accept && emit) begin
        out_valid  <= 1'b1;
        start_x    <= pend_start_next;
        end_x      <= pend_end_next;
        event_line <= EW'(pend_line_next) + EW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/vccd_cell.sv =====
// ----------------------------------------------------------------------------
// vccd_cell
// One stage of the out-of-range history line: holds one flag and passes it
// on to the next cell on every item; cleared at line end.
// ----------------------------------------------------------------------------
module vccd_cell (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic clear,
  input  logic din,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (shift) begin
      q <= clear ? 1'b0 : din;
    end
  end

endmodule

// ===== src/vccd_thresh.sv =====
// ----------------------------------------------------------------------------
// vccd_thresh
// Trigger thresholds: white plus margin and black minus margin, saturated.
// Two register stages (margin, then thresholds).
// ----------------------------------------------------------------------------
module vccd_thresh (
  input  logic                           clk,
  input  logic [vccd_pkg::SAMPLE_W-1:0]  white_level,
  input  logic [vccd_pkg::SAMPLE_W-1:0]  black_level,
  output vccd_pkg::thr_t                 thr
);

  logic [vccd_pkg::DIFF_W-1:0]   dbl;
  logic [vccd_pkg::PROD_W-1:0]   prod;
  logic [vccd_pkg::MARGIN_W-1:0] margin;
  logic [vccd_pkg::DIFF_W-1:0]   hi_sum;
  logic [vccd_pkg::SAMPLE_W-1:0] margin_s;

  always_comb begin
    dbl = '0;
    if (white_level >= black_level) begin
      dbl = {white_level - black_level, 1'b0};
    end
    prod = vccd_pkg::PROD_W'(dbl) * vccd_pkg::PROD_W'(vccd_pkg::RECIP_25);
  end

  always_ff @(posedge clk) begin
    margin <= prod[vccd_pkg::RECIP_SHIFT +: vccd_pkg::MARGIN_W];
  end

  always_comb begin
    margin_s = vccd_pkg::SAMPLE_W'(margin);
    hi_sum   = vccd_pkg::DIFF_W'(white_level) + vccd_pkg::DIFF_W'(margin);
  end

  always_ff @(posedge clk) begin
    thr.hi <= hi_sum[vccd_pkg::SAMPLE_W] ? '1 : hi_sum[vccd_pkg::SAMPLE_W-1:0];
    thr.lo <= (black_level > margin_s) ? black_level - margin_s : '0;
  end

endmodule
